// ----- rtl/prioritized_slot_table_top_defines.svh -----
// ----------------------------------------------------------------------------
// Prioritized slot table: assertion macros
// Shared property forms for the checker of the prioritized slot table.
// ----------------------------------------------------------------------------
`ifndef PRIORITIZED_SLOT_TABLE_TOP_DEFINES_SVH
`define PRIORITIZED_SLOT_TABLE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// Prioritized slot table package
// Command and status codes, word layouts and control bundles.
// ----------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned SLOTS_DEF    = 8;
  localparam int unsigned MAX_PRIO_DEF = 31;

  localparam int unsigned ITEM_W  = 16;
  localparam int unsigned DEST_W  = 8;
  localparam int unsigned STEPS_W = 8;
  localparam int unsigned REQP_W  = 5;
  localparam int unsigned COUNT_W = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [STEPS_W-1:0] NEAR_STEPS = STEPS_W'(3);

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_ROUTE  = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_ACK    = 3'd3,
    CMD_CANCEL = 3'd4,
    CMD_FETCH  = 3'd5,
    CMD_REMOVE = 3'd6,
    CMD_COUNT  = 3'd7
  } pst_cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } pst_status_t;

  typedef struct packed {
    pst_cmd_t            cmd;
    logic [ITEM_W-1:0]   item_id;
    logic [DEST_W-1:0]   dest_id;
    logic                has_transfer;
    logic [STEPS_W-1:0]  steps_left;
    logic [REQP_W-1:0]   req_priority;
    logic                force_recall;
    logic                carrier_notified;
  } pst_in_t;

  typedef struct packed {
    pst_status_t         status;
    logic                found;
    logic [ITEM_W-1:0]   out_item_id;
    logic [COUNT_W-1:0]  match_count;
    logic                has_room;
    logic                slot_freed;
  } pst_out_t;

  // One table entry without its priority, whose width follows a parameter.
  typedef struct packed {
    logic [ITEM_W-1:0]   item;
    logic [DEST_W-1:0]   dest;
    logic                pending;
  } pst_slot_t;

  typedef struct packed {
    logic load;
    logic step;
  } pst_cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic pass2;
  } pst_scan_ctrl_t;

  typedef struct packed {
    logic                found;
    logic                hit;
    logic                need_pass2;
    logic [COUNT_W-1:0]  match_count;
    logic [ITEM_W-1:0]   out_item_id;
  } pst_scan_res_t;

endpackage

// ----- rtl/pst_cell.sv -----
// ----------------------------------------------------------------------------
// Prioritized slot table: storage cell
// Holds one entry; takes its upper neighbor's entry, the recirculated head
// entry, or a newly added entry.
// ----------------------------------------------------------------------------
module pst_cell #(
  parameter int unsigned SLOTS        = pst_pkg::SLOTS_DEF,
  parameter int unsigned MAX_PRIORITY = pst_pkg::MAX_PRIO_DEF,
  parameter int unsigned IDX          = 0,
  localparam int unsigned IDX_W       = $clog2(SLOTS),
  localparam int unsigned PRIO_W      = $clog2(MAX_PRIORITY + 1)
) (
  input  logic                   clk,
  input  pst_pkg::pst_cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]       load_idx,
  input  logic [IDX_W-1:0]       tail,
  input  pst_pkg::pst_slot_t     ext_slot,
  input  logic [PRIO_W-1:0]      ext_prio,
  input  pst_pkg::pst_slot_t     next_slot,
  input  logic [PRIO_W-1:0]      next_prio,
  output pst_pkg::pst_slot_t     slot,
  output logic [PRIO_W-1:0]      prio
);
  import pst_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic take_ext;
  logic take_next;

  // The tail cell closes the ring; cells below it shift toward the head.
  assign take_ext  = (ctrl.load && (load_idx == MY_IDX)) || (ctrl.step && (tail == MY_IDX));
  assign take_next = ctrl.step && (MY_IDX < tail);

  always_ff @(posedge clk) begin
    if (take_ext) begin
      slot <= ext_slot;
      prio <= ext_prio;
    end else if (take_next) begin
      slot <= next_slot;
      prio <= next_prio;
    end
  end

endmodule

// ----- rtl/pst_scan.sv -----
// ----------------------------------------------------------------------------
// Prioritized slot table: head scanner
// Inspects the entry at the head of the ring each step, keeps the running
// selection and counts, and edits or drops the entry as it recirculates.
// ----------------------------------------------------------------------------
module pst_scan #(
  parameter int unsigned SLOTS        = pst_pkg::SLOTS_DEF,
  parameter int unsigned MAX_PRIORITY = pst_pkg::MAX_PRIO_DEF,
  localparam int unsigned IDX_W       = $clog2(SLOTS),
  localparam int unsigned PRIO_W      = $clog2(MAX_PRIORITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pst_pkg::pst_scan_ctrl_t ctrl,
  input  pst_pkg::pst_in_t       cmd_word,
  input  logic [IDX_W-1:0]       idx,
  input  pst_pkg::pst_slot_t     head_slot,
  input  logic [PRIO_W-1:0]      head_prio,
  output pst_pkg::pst_slot_t     mod_slot,
  output logic [PRIO_W-1:0]      mod_prio,
  output logic                   drop,
  output pst_pkg::pst_scan_res_t res
);
  import pst_pkg::*;

  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(MAX_PRIORITY);

  logic               sel_valid;
  logic [IDX_W-1:0]   sel;
  logic [PRIO_W-1:0]  best;
  logic               hit;
  logic               query_found;
  logic [COUNT_W-1:0] count;
  logic [ITEM_W-1:0]  out_id;

  logic dest_hit;
  logic id_hit;
  logic at_sel;
  logic take;
  logic sel_cmd;

  assign dest_hit = (head_slot.dest == cmd_word.dest_id) && (cmd_word.dest_id != '0);
  assign id_hit   = (head_slot.item == cmd_word.item_id);
  assign at_sel   = sel_valid && (sel == idx);
  assign sel_cmd  = (cmd_word.cmd == CMD_ACK) || (cmd_word.cmd == CMD_CANCEL) ||
                    (cmd_word.cmd == CMD_FETCH);

  always_comb begin
    mod_slot = head_slot;
    mod_prio = head_prio;
    drop     = 1'b0;
    take     = 1'b0;
    if (ctrl.pass2) begin
      if (at_sel) begin
        unique case (cmd_word.cmd)
          CMD_ACK:    mod_slot.pending = 1'b0;
          CMD_CANCEL: mod_slot.pending = 1'b1;
          CMD_FETCH:  drop = 1'b1;
          default:    ;
        endcase
      end
    end else begin
      unique case (cmd_word.cmd)
        CMD_ROUTE: begin
          if (id_hit && !hit) begin
            if (cmd_word.dest_id == '0) begin
              mod_slot.dest    = '0;
              mod_slot.pending = 1'b1;
            end else if ((head_slot.dest != cmd_word.dest_id) || cmd_word.force_recall) begin
              mod_slot.dest    = cmd_word.dest_id;
              mod_slot.pending = !cmd_word.carrier_notified;
            end
          end
        end
        CMD_ACK: begin
          take = head_slot.pending && dest_hit && (!sel_valid || (head_prio > best));
          // Every new running maximum ages by one unless at the top priority.
          if (take && (head_prio != PRIO_MAX)) begin
            mod_prio = head_prio + 1'b1;
          end
        end
        CMD_CANCEL: take = !head_slot.pending && dest_hit && (!sel_valid || (head_prio < best));
        CMD_FETCH:  take = dest_hit && (!sel_valid || !head_slot.pending);
        CMD_REMOVE: drop = id_hit && !hit;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sel_valid   <= 1'b0;
      hit         <= 1'b0;
      query_found <= 1'b0;
      count       <= '0;
      out_id      <= '0;
    end else if (ctrl.step) begin
      if (take) begin
        sel_valid <= 1'b1;
        sel       <= idx;
        best      <= head_prio;
      end
      if (!ctrl.pass2 && id_hit &&
          ((cmd_word.cmd == CMD_ROUTE) || (cmd_word.cmd == CMD_REMOVE))) begin
        hit <= 1'b1;
      end
      if (!ctrl.pass2 && (cmd_word.cmd == CMD_QUERY) && dest_hit && head_slot.pending) begin
        query_found <= 1'b1;
      end
      if (!ctrl.pass2 && (cmd_word.cmd == CMD_COUNT) && dest_hit && (count != COUNT_MAX)) begin
        count <= count + 1'b1;
      end
      if (ctrl.pass2 && drop) begin
        out_id <= head_slot.item;
      end
    end
  end

  always_comb begin
    res.found       = (cmd_word.cmd == CMD_QUERY) ? query_found : (sel_cmd && sel_valid);
    res.hit         = hit;
    res.need_pass2  = sel_cmd && sel_valid;
    res.match_count = count;
    res.out_item_id = out_id;
  end

endmodule

// ----- rtl/prioritized_slot_table_top.sv -----
// ----------------------------------------------------------------------------
// Prioritized slot table: top level
// A compacted table of waiting items kept in a ring of cells that rotates
// past a single scanner; add, route, query, ack, cancel, fetch, remove, count.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Word
//   in       input      in_valid / in_stall    pst_in_t  (one command)
//   out      output     out_valid / out_stall  pst_out_t (one result per command)
//
// An add writes its entry into the first free cell, if there is room, as it
// is accepted and goes to the finish state, which loads its result and frees
// the input. Other commands rotate the table past the head scanner once, and
// ack, cancel and fetch with a match once more, before the finish state.
// A result held by out_stall lets the next command run but holds it in its
// last cycle. Reset (rst, synchronous) empties the table and the output.
//
module prioritized_slot_table_top #(
  parameter int unsigned SLOTS        = pst_pkg::SLOTS_DEF,
  parameter int unsigned MAX_PRIORITY = pst_pkg::MAX_PRIO_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pst_pkg::pst_in_t  in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output pst_pkg::pst_out_t out_word
);
  import pst_pkg::*;

  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned PRIO_W = $clog2(MAX_PRIORITY + 1);
  localparam int unsigned SUM_W  = REQP_W + 1;
  localparam int unsigned CMP_W  = (SUM_W > PRIO_W) ? SUM_W : PRIO_W;

  localparam logic [CNT_W-1:0]  OCC_FULL   = CNT_W'(SLOTS);
  localparam logic [PRIO_W-1:0] PRIO_MAX   = PRIO_W'(MAX_PRIORITY);
  localparam logic [SUM_W-1:0]  BONUS_NEAR = SUM_W'(2);
  localparam logic [SUM_W-1:0]  BONUS_LAST = SUM_W'(1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PASS1  = 4'b0010,
    S_PASS2  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  step_cnt;
  logic [IDX_W-1:0]  tail;
  pst_in_t           cmd_word;
  logic              add_full;

  logic              in_acc;
  logic              stepping;
  logic              out_free;
  logic [CNT_W-1:0]  occ_m1;
  logic              is_add;
  logic              has_space;

  pst_cell_ctrl_t    cell_ctrl;
  pst_scan_ctrl_t    scan_ctrl;
  pst_scan_res_t     scan_res;

  pst_slot_t         cell_slot [SLOTS];
  logic [PRIO_W-1:0] cell_prio [SLOTS];

  pst_slot_t         new_slot;
  logic [PRIO_W-1:0] new_prio;
  pst_slot_t         mod_slot;
  logic [PRIO_W-1:0] mod_prio;
  pst_slot_t         ext_slot;
  logic [PRIO_W-1:0] ext_prio;
  logic              drop;

  logic [SUM_W-1:0]  base_prio;
  logic [SUM_W-1:0]  sum_prio;

  pst_out_t          result;

  // The block works on one command at a time; the output register lets the
  // next one start while a result is still waiting.
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign occ_m1    = occ - 1'b1;
  assign is_add    = (in_word.cmd == CMD_ADD);
  assign has_space = (occ < OCC_FULL);

  // A pass steps once per stored entry; the cycle with step_cnt at occupancy
  // closes the pass.
  assign stepping = ((state == S_PASS1) || (state == S_PASS2)) && (step_cnt != occ);

  // Priority of a new entry with a transfer: a bonus if near its end, plus the
  // request priority, saturated at the top priority; zero with no transfer.
  always_comb begin
    if (in_word.steps_left < NEAR_STEPS) begin
      base_prio = BONUS_NEAR;
    end else if (in_word.steps_left == NEAR_STEPS) begin
      base_prio = BONUS_LAST;
    end else begin
      base_prio = '0;
    end
    sum_prio = in_word.has_transfer ? (base_prio + SUM_W'(in_word.req_priority)) : '0;
    if (CMP_W'(sum_prio) > CMP_W'(MAX_PRIORITY)) begin
      new_prio = PRIO_MAX;
    end else begin
      new_prio = PRIO_W'(sum_prio);
    end
    new_slot.item    = in_word.item_id;
    new_slot.dest    = '0;
    new_slot.pending = 1'b0;
  end

  assign cell_ctrl.load = in_acc && is_add && has_space;
  assign cell_ctrl.step = stepping;

  // Adds write straight into the first free cell; during a pass the tail
  // cell takes the head entry back after the scanner has seen it.
  assign ext_slot = cell_ctrl.load ? new_slot : mod_slot;
  assign ext_prio = cell_ctrl.load ? new_prio : mod_prio;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    pst_slot_t         nxt_slot;
    logic [PRIO_W-1:0] nxt_prio;

    if (k == SLOTS - 1) begin : g_last
      assign nxt_slot = cell_slot[k];
      assign nxt_prio = cell_prio[k];
    end else begin : g_mid
      assign nxt_slot = cell_slot[k+1];
      assign nxt_prio = cell_prio[k+1];
    end

    pst_cell #(
      .SLOTS        (SLOTS),
      .MAX_PRIORITY (MAX_PRIORITY),
      .IDX          (k)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .load_idx  (occ[IDX_W-1:0]),
      .tail      (tail),
      .ext_slot  (ext_slot),
      .ext_prio  (ext_prio),
      .next_slot (nxt_slot),
      .next_prio (nxt_prio),
      .slot      (cell_slot[k]),
      .prio      (cell_prio[k])
    );
  end

  assign scan_ctrl.clear = in_acc;
  assign scan_ctrl.step  = stepping;
  assign scan_ctrl.pass2 = (state == S_PASS2);

  // The entry at the head during step t is always the entry that sat at
  // index t when the pass began, even after a drop earlier in the pass.
  pst_scan #(
    .SLOTS        (SLOTS),
    .MAX_PRIORITY (MAX_PRIORITY)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (scan_ctrl),
    .cmd_word  (cmd_word),
    .idx       (step_cnt[IDX_W-1:0]),
    .head_slot (cell_slot[0]),
    .head_prio (cell_prio[0]),
    .mod_slot  (mod_slot),
    .mod_prio  (mod_prio),
    .drop      (drop),
    .res       (scan_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            cmd_word <= in_word;
            step_cnt <= '0;
            tail     <= occ_m1[IDX_W-1:0];
            if (is_add) begin
              add_full <= !has_space;
              if (has_space) begin
                occ <= occ + 1'b1;
              end
              state <= S_FINISH;
            end else begin
              state <= S_PASS1;
            end
          end
        end
        S_PASS1: begin
          if (stepping) begin
            step_cnt <= step_cnt + 1'b1;
            // A dropped entry shortens the ring from the next step on.
            if (drop) begin
              tail <= tail - 1'b1;
            end
          end else begin
            step_cnt <= '0;
            tail     <= occ_m1[IDX_W-1:0];
            if ((cmd_word.cmd == CMD_REMOVE) && scan_res.hit) begin
              occ <= occ_m1;
            end
            state <= scan_res.need_pass2 ? S_PASS2 : S_FINISH;
          end
        end
        S_PASS2: begin
          if (stepping) begin
            step_cnt <= step_cnt + 1'b1;
            if (drop) begin
              tail <= tail - 1'b1;
            end
          end else begin
            if (cmd_word.cmd == CMD_FETCH) begin
              occ <= occ_m1;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_word.cmd)
      CMD_ADD:    result.status = add_full ? ST_FULL : ST_OK;
      CMD_ROUTE,
      CMD_REMOVE: result.status = scan_res.hit ? ST_OK : ST_NOT_FOUND;
      default:    result.status = ST_OK;
    endcase
    result.found       = scan_res.found;
    result.out_item_id = scan_res.out_item_id;
    result.match_count = scan_res.match_count;
    result.has_room    = has_space;
    result.slot_freed  = ((cmd_word.cmd == CMD_REMOVE) && scan_res.hit) ||
                         ((cmd_word.cmd == CMD_FETCH) && scan_res.found);
  end

  // Output register: a new result loads only once the previous word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      out_word <= result;
    end
  end

endmodule

// ----- rtl/pst_checker.sv -----
// ----------------------------------------------------------------------------
// Prioritized slot table: port checker
// Watches the top level's ports and checks handshake and result consistency.
// ----------------------------------------------------------------------------
`include "prioritized_slot_table_top_defines.svh"

module pst_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input pst_pkg::pst_in_t  in_word,
  input logic              out_valid,
  input logic              out_stall,
  input pst_pkg::pst_out_t out_word
);
  import pst_pkg::*;

  // A stalled result word stays offered and unchanged.
  `PST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word), "result word changed while stalled")

  // The table works on one command at a time, so it is busy right after taking one.
  `PST_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "command accepted while busy")

  // Freeing an entry always leaves room in the table.
  `PST_ASSERT_NOW(a_freed_room, clk, rst, out_valid && out_word.slot_freed, out_word.has_room, "freed entry without room")

  // A refused add means the table is still full and nothing was removed.
  `PST_ASSERT_NOW(a_full_refusal, clk, rst, out_valid && (out_word.status == ST_FULL), !out_word.has_room && !out_word.slot_freed, "full status with room left")

endmodule

bind prioritized_slot_table_top pst_checker u_pst_checker (.*);

// ----- verif/prioritized_slot_table_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Prioritized slot table: self-checking testbench
// Drives command words through the valid/stall input channel and checks each
// result word against a behavioral table model held in the bench. Idle and
// stall patterns change from phase to phase.
// ----------------------------------------------------------------------------
module prioritized_slot_table_top_tb;
  import pst_pkg::*;

  localparam int unsigned SLOTS    = SLOTS_DEF;
  localparam int unsigned MAX_PRIO = MAX_PRIO_DEF;

  // Priority bonus for an item that is close to the end of its transfer.
  localparam int unsigned NEAR_BONUS  = 2;
  localparam int unsigned EXACT_BONUS = 1;

  // A comfortable margin, in clock cycles, for the last result to drain out.
  localparam int unsigned TAIL_CYCLES = 4 * SLOTS + 16;

  // Cycles with no word moving on either channel before the run is given up.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  localparam int unsigned RANDOM_PER_PHASE = 80;
  localparam int unsigned PHASES           = 5;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  pst_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pst_out_t out_word;

  prioritized_slot_table_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #2 clk = ~clk;

  // Commands waiting to be driven and results waiting to be seen.
  pst_in_t  cmd_queue[$];
  pst_out_t expected_results[$];

  int unsigned words_queued  = 0;
  int unsigned results_seen  = 0;
  int unsigned error_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        in_taken      = 1'b0;

  // Shadow copy of the table. Only slots below fill_level are ever read.
  logic [ITEM_W-1:0] tbl_item    [SLOTS];
  logic [DEST_W-1:0] tbl_dest    [SLOTS];
  logic              tbl_pending [SLOTS];
  int unsigned       tbl_prio    [SLOTS];
  int unsigned       fill_level = 0;

  function automatic int find_slot(logic [ITEM_W-1:0] id);
    for (int k = 0; k < int'(fill_level); k++) begin
      if (tbl_item[k] == id) return k;
    end
    return -1;
  endfunction

  // Removes one entry and closes the gap, keeping the order of arrival.
  function automatic void drop_slot(int idx);
    for (int k = idx; k + 1 < int'(fill_level); k++) begin
      tbl_item[k]    = tbl_item[k + 1];
      tbl_dest[k]    = tbl_dest[k + 1];
      tbl_pending[k] = tbl_pending[k + 1];
      tbl_prio[k]    = tbl_prio[k + 1];
    end
    fill_level--;
  endfunction

  // Applies one command to the shadow table and returns the result it gives.
  function automatic pst_out_t apply_command(pst_in_t w);
    pst_out_t    r;
    int          sel;
    int          best;
    int          low;
    int unsigned prio;
    r        = '0;
    r.status = ST_OK;
    sel      = -1;
    case (w.cmd)
      CMD_ADD: begin
        if (fill_level >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          prio = 0;
          if (w.has_transfer) begin
            if (w.steps_left < NEAR_STEPS) prio = NEAR_BONUS;
            else if (w.steps_left == NEAR_STEPS) prio = EXACT_BONUS;
            prio += w.req_priority;
          end
          if (prio > MAX_PRIO) prio = MAX_PRIO;
          tbl_item[fill_level]    = w.item_id;
          tbl_dest[fill_level]    = '0;
          tbl_pending[fill_level] = 1'b0;
          tbl_prio[fill_level]    = prio;
          fill_level++;
        end
      end
      CMD_ROUTE: begin
        sel = find_slot(w.item_id);
        if (sel < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (w.dest_id == '0) begin
          tbl_dest[sel]    = '0;
          tbl_pending[sel] = 1'b1;
        end else if (tbl_dest[sel] != w.dest_id || w.force_recall) begin
          tbl_dest[sel]    = w.dest_id;
          tbl_pending[sel] = !w.carrier_notified;
        end
      end
      CMD_QUERY: begin
        if (w.dest_id != '0) begin
          for (int k = 0; k < int'(fill_level); k++) begin
            if (tbl_pending[k] && tbl_dest[k] == w.dest_id) r.found = 1'b1;
          end
        end
      end
      CMD_ACK: begin
        // Every new running maximum ages by one on the way, unless at the top.
        best = -1;
        if (w.dest_id != '0) begin
          for (int k = 0; k < int'(fill_level); k++) begin
            if (tbl_pending[k] && tbl_dest[k] == w.dest_id && int'(tbl_prio[k]) > best) begin
              best = int'(tbl_prio[k]);
              sel  = k;
              if (tbl_prio[k] < MAX_PRIO) tbl_prio[k]++;
            end
          end
        end
        if (sel >= 0) begin
          tbl_pending[sel] = 1'b0;
          r.found          = 1'b1;
        end
      end
      CMD_CANCEL: begin
        low = int'(MAX_PRIO) + 1;
        if (w.dest_id != '0) begin
          for (int k = 0; k < int'(fill_level); k++) begin
            if (!tbl_pending[k] && tbl_dest[k] == w.dest_id && int'(tbl_prio[k]) < low) begin
              low = int'(tbl_prio[k]);
              sel = k;
            end
          end
        end
        if (sel >= 0) begin
          tbl_pending[sel] = 1'b1;
          r.found          = 1'b1;
        end
      end
      CMD_FETCH: begin
        // The last entry not pending wins; otherwise the first match.
        if (w.dest_id != '0) begin
          for (int k = 0; k < int'(fill_level); k++) begin
            if (tbl_dest[k] == w.dest_id && (sel < 0 || !tbl_pending[k])) sel = k;
          end
        end
        if (sel >= 0) begin
          r.found       = 1'b1;
          r.out_item_id = tbl_item[sel];
          r.slot_freed  = 1'b1;
          drop_slot(sel);
        end
      end
      CMD_REMOVE: begin
        sel = find_slot(w.item_id);
        if (sel < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.slot_freed = 1'b1;
          drop_slot(sel);
        end
      end
      CMD_COUNT: begin
        if (w.dest_id != '0) begin
          for (int k = 0; k < int'(fill_level); k++) begin
            if (tbl_dest[k] == w.dest_id && r.match_count != COUNT_MAX) r.match_count++;
          end
        end
      end
    endcase
    r.has_room = (fill_level < SLOTS);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Receiving side: compare the result word first, then predict the command
  // accepted at the same edge, since that result can only come later.
  always @(posedge clk) begin
    pst_out_t want;
    pst_out_t pred;
    in_taken <= in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result word arrived with no command outstanding");
        error_count++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        check_field("status",      32'(want.status),      32'(out_word.status));
        check_field("found",       32'(want.found),       32'(out_word.found));
        check_field("out_item_id", 32'(want.out_item_id), 32'(out_word.out_item_id));
        check_field("match_count", 32'(want.match_count), 32'(out_word.match_count));
        check_field("has_room",    32'(want.has_room),    32'(out_word.has_room));
        check_field("slot_freed",  32'(want.slot_freed),  32'(out_word.slot_freed));
      end
    end
    if (!rst && in_valid && !in_stall) begin
      pred             = apply_command(in_word);
      expected_results = {expected_results, pred};
    end
  end

  // Sending side: a word stays put until it is taken; only then may the line
  // go idle or move on to the next queued command.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_word  <= cmd_queue[0];
        cmd_queue.delete(0);
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog on progress: any word moving on either side resets the count.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_word(input pst_in_t w);
    cmd_queue = {cmd_queue, w};
    words_queued++;
  endtask

  function automatic pst_in_t make_word(pst_cmd_t c, logic [ITEM_W-1:0] id,
                                        logic [DEST_W-1:0] d);
    pst_in_t w;
    w         = '0;
    w.cmd     = c;
    w.item_id = id;
    w.dest_id = d;
    return w;
  endfunction

  function automatic pst_in_t make_add(logic [ITEM_W-1:0] id, logic ht,
                                       logic [STEPS_W-1:0] steps,
                                       logic [REQP_W-1:0] reqp);
    pst_in_t w;
    w              = make_word(CMD_ADD, id, '0);
    w.has_transfer = ht;
    w.steps_left   = steps;
    w.req_priority = reqp;
    return w;
  endfunction

  function automatic pst_in_t make_route(logic [ITEM_W-1:0] id, logic [DEST_W-1:0] d,
                                         logic force_bit, logic notified);
    pst_in_t w;
    w                  = make_word(CMD_ROUTE, id, d);
    w.force_recall     = force_bit;
    w.carrier_notified = notified;
    return w;
  endfunction

  // Random commands draw ids from a small set so that route and remove hit
  // entries that are really in the table; a few ids are fully random.
  function automatic pst_in_t random_word(int unsigned add_pct);
    pst_in_t     w;
    int unsigned roll;
    logic        hi;
    logic [1:0]  low_bits;
    hi       = 1'($urandom_range(0, 1));
    low_bits = 2'($urandom_range(0, 3));
    w        = '0;
    if ($urandom_range(0, 99) < 85) w.item_id = {{14{hi}}, low_bits};
    else w.item_id = ITEM_W'($urandom_range(0, 65535));
    roll = $urandom_range(0, 99);
    if (roll < 10) w.dest_id = '0;
    else if (roll < 85) w.dest_id = DEST_W'($urandom_range(1, 3));
    else w.dest_id = DEST_W'($urandom_range(0, 255));
    w.has_transfer     = 1'($urandom_range(0, 1));
    w.steps_left       = STEPS_W'($urandom_range(0, 1) ? $urandom_range(0, 5) :
                                                         $urandom_range(0, 255));
    w.req_priority     = REQP_W'($urandom_range(0, 31));
    w.force_recall     = 1'($urandom_range(0, 1));
    w.carrier_notified = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < add_pct) w.cmd = CMD_ADD;
    else if (roll < add_pct + 25) w.cmd = CMD_ROUTE;
    else w.cmd = pst_cmd_t'(3'($urandom_range(2, 7)));
    return w;
  endfunction

  task automatic wait_drained();
    while (results_seen != words_queued) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, with no idling. First fill the table to the brim while
    // covering the priority rules: no transfer, saturation, exactly three
    // steps left, under three steps left, and a duplicate id.
    queue_word(make_add(16'hFFFF, 1'b0, 8'd0,   5'd31));
    queue_word(make_add(16'h0001, 1'b1, 8'd0,   5'd31));
    queue_word(make_add(16'h0002, 1'b1, 8'd3,   5'd0));
    queue_word(make_add(16'h0003, 1'b1, 8'd255, 5'd31));
    queue_word(make_add(16'h0000, 1'b1, 8'd2,   5'd5));
    queue_word(make_add(16'h0001, 1'b1, 8'd4,   5'd10));
    queue_word(make_add(16'h8000, 1'b0, 8'd1,   5'd0));
    queue_word(make_add(16'h0004, 1'b1, 8'd1,   5'd0));
    // The table is full now, so this one must be refused.
    queue_word(make_add(16'h0005, 1'b1, 8'd0,   5'd1));
    queue_word(make_word(CMD_COUNT, 16'h0000, 8'd0));
    // Routing: pending and notified, unchanged without recall, forced, to
    // destination zero, and an unknown id.
    queue_word(make_route(16'hFFFF, 8'd255, 1'b0, 1'b0));
    queue_word(make_route(16'h0001, 8'd255, 1'b0, 1'b1));
    queue_word(make_route(16'h0001, 8'd255, 1'b0, 1'b0));
    queue_word(make_route(16'h0002, 8'd255, 1'b1, 1'b0));
    queue_word(make_route(16'h0003, 8'd0,   1'b0, 1'b1));
    queue_word(make_route(16'h1234, 8'd7,   1'b0, 1'b0));
    queue_word(make_word(CMD_QUERY,  16'h0000, 8'd255));
    queue_word(make_word(CMD_QUERY,  16'h0000, 8'd0));
    queue_word(make_word(CMD_COUNT,  16'h0000, 8'd255));
    queue_word(make_word(CMD_ACK,    16'h0000, 8'd255));
    queue_word(make_word(CMD_ACK,    16'h0000, 8'd0));
    queue_word(make_word(CMD_CANCEL, 16'h0000, 8'd255));
    queue_word(make_word(CMD_FETCH,  16'h0000, 8'd255));
    queue_word(make_word(CMD_FETCH,  16'h0000, 8'd7));
    queue_word(make_word(CMD_REMOVE, 16'h0001, 8'd0));
    queue_word(make_word(CMD_REMOVE, 16'h5555, 8'd0));
    wait_drained();

    // Random part. Phases set idle and stall profiles (the first and last
    // have neither); within a phase the mix swings between filling and
    // draining, so both the full and the empty table recur again and again.
    for (int phase = 0; phase < int'(PHASES); phase++) begin
      case (phase)
        1:       begin send_idle_pct = 70; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 70; end
        3:       begin send_idle_pct = 10; stall_pct = 10; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      for (int n = 0; n < int'(RANDOM_PER_PHASE); n++) begin
        queue_word(random_word(((n / 16) % 2 == 0) ? 60 : 15));
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_cell.sv
rtl/pst_scan.sv
rtl/prioritized_slot_table_top.sv
rtl/pst_checker.sv
verif/prioritized_slot_table_top_tb.sv
